// ===== rtl/core/slte_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, sizes and helpers for the sorted line table engine.
// No dependencies; every other file of the block imports this package.
package slte_pkg;

   localparam int TABLE_DEPTH   = 1024;
   localparam int POSITION_BITS = 32;
   localparam int IDX_W         = $clog2(TABLE_DEPTH);
   localparam int CNT_W         = IDX_W + 1;
   localparam int WIDTH_W       = 24;
   localparam int IN_W          = 32;

   typedef enum logic [2:0] {
      MODE_INSERT       = 3'd0,
      MODE_REMOVE_LINES = 3'd1,
      MODE_REMOVE_RANGE = 3'd2,
      MODE_LOOKUP_OFF   = 3'd3,
      MODE_LOOKUP_PIX   = 3'd4,
      MODE_BUMP_ORG     = 3'd5,
      MODE_BUMP_OFF     = 3'd6,
      MODE_MAX_WIDTH    = 3'd7
   } mode_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_RANGE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_SHIFT,
      CELL_BUMP_OFF,
      CELL_BUMP_ORG,
      CELL_CMP_OFF,
      CELL_CMP_ORG
   } cell_op_type;

   typedef struct packed {
      mode_type          mode;
      logic [CNT_W-1:0]  line_index;
      logic [CNT_W-1:0]  line_count;
      logic [IN_W-1:0]   from_offset;
      logic [IN_W-1:0]   to_offset;
      logic [IN_W-1:0]   pixel_pos;
      logic [IN_W-1:0]   bump_delta;
      logic [IN_W-1:0]   new_offset;
      logic [IN_W-1:0]   new_origin;
      logic [WIDTH_W-1:0] new_width;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]   found_line;
      logic [WIDTH_W-1:0] widest;
      logic [CNT_W-1:0]   entries_used;
      status_type         status;
   } rsp_type;

   typedef struct packed {
      logic [POSITION_BITS-1:0] offset;
      logic [POSITION_BITS-1:0] origin;
      logic [WIDTH_W-1:0]       width;
   } rec_type;

   typedef struct packed {
      cell_op_type              op;
      logic [CNT_W-1:0]         index;
      logic [CNT_W-1:0]         total;
      logic [POSITION_BITS-1:0] key;
      logic [POSITION_BITS-1:0] delta;
      rec_type                  new_rec;
   } cell_ctrl_type;

   function automatic logic [POSITION_BITS-1:0] pos_in(input logic [IN_W-1:0] v);
      logic [63:0] x;
      x = 64'($signed(v));
      return x[POSITION_BITS-1:0];
   endfunction

endpackage

// ===== rtl/core/slte_cell.sv =====
`timescale 1ns / 1ps
// One table cell: holds a single line record, a compare flag and a running max.
// Depends on slte_pkg.
module slte_cell import slte_pkg::*; (
   input  logic               clock,
   input  logic [IDX_W-1:0]   cell_index,
   input  cell_ctrl_type      ctrl,
   input  rec_type            below_rec,
   input  rec_type            above_rec,
   input  logic [WIDTH_W-1:0] above_max,
   output rec_type            rec,
   output logic               ge,
   output logic [WIDTH_W-1:0] max_out
);

   rec_type            rec_ff, rec_in;
   logic               ge_ff, ge_in;
   logic [WIDTH_W-1:0] max_ff, max_in;
   logic [WIDTH_W-1:0] own_width;
   logic [CNT_W-1:0]   my_pos;
   logic               at_or_above;

   assign my_pos      = {1'b0, cell_index};
   assign at_or_above = my_pos >= ctrl.index;

   always_comb begin
      rec_in = rec_ff;
      ge_in  = ge_ff;
      case (ctrl.op)
         CELL_INSERT: begin
            if (my_pos == ctrl.index) begin
               rec_in = ctrl.new_rec;
            end else if (at_or_above) begin
               rec_in = below_rec;
            end
         end
         CELL_SHIFT: begin
            if (at_or_above) begin
               rec_in = above_rec;
            end
         end
         CELL_BUMP_OFF: begin
            if (at_or_above) begin
               rec_in.offset = rec_ff.offset + ctrl.delta;
            end
         end
         CELL_BUMP_ORG: begin
            if (at_or_above) begin
               rec_in.origin = rec_ff.origin + ctrl.delta;
            end
         end
         CELL_CMP_OFF: ge_in = $signed(ctrl.key) >= $signed(rec_ff.offset);
         CELL_CMP_ORG: ge_in = $signed(ctrl.key) >= $signed(rec_ff.origin);
         default: ;
      endcase
   end

   assign own_width = (my_pos < ctrl.total) ? rec_ff.width : '0;
   assign max_in    = (own_width > above_max) ? own_width : above_max;

   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
      ge_ff  <= ge_in;
      max_ff <= max_in;
   end

   assign rec     = rec_ff;
   assign ge      = ge_ff;
   assign max_out = max_ff;

endmodule

// ===== rtl/core/slte_chain.sv =====
`timescale 1ns / 1ps
// Row of table cells linked to their neighbors; exposes compare flags and max.
// Depends on slte_pkg and slte_cell.
module slte_chain import slte_pkg::*; (
   input  logic                   clock,
   input  cell_ctrl_type          ctrl,
   output logic [TABLE_DEPTH-1:0] ge_vec,
   output logic [WIDTH_W-1:0]     max_head
);

   rec_type            rec_q [TABLE_DEPTH];
   logic [WIDTH_W-1:0] max_q [TABLE_DEPTH];

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      rec_type            below;
      rec_type            above;
      logic [WIDTH_W-1:0] above_m;

      if (i == 0) begin : g_first
         assign below = ctrl.new_rec;
      end else begin : g_mid
         assign below = rec_q[i-1];
      end

      if (i == TABLE_DEPTH - 1) begin : g_last
         assign above   = rec_q[i];
         assign above_m = '0;
      end else begin : g_inner
         assign above   = rec_q[i+1];
         assign above_m = max_q[i+1];
      end

      slte_cell u_cell (
         .clock      (clock),
         .cell_index (IDX_W'(i)),
         .ctrl       (ctrl),
         .below_rec  (below),
         .above_rec  (above),
         .above_max  (above_m),
         .rec        (rec_q[i]),
         .ge         (ge_vec[i]),
         .max_out    (max_q[i])
      );
   end

   assign max_head = max_q[0];

endmodule

// ===== rtl/core/sorted_line_table_engine.sv =====
`timescale 1ns / 1ps
// Top level: operation sequencer around the cell row, request and response words.
// Depends on slte_pkg and slte_chain.
//
// One request word at a time is taken; its response word is held in an output
// register, so the next request is taken while that response waits. The
// sequencer steps the cell row per mode: insert and the two bump modes act on
// the row and answer; remove lines shifts the row once per removed line; offset
// and pixel lookups compare the key in every cell, then binary-search the flags;
// remove range runs two lookups, shifts out the run between them and bumps the
// offsets above; max width waits as the running maximum ripples one cell per
// cycle toward cell zero. Errors go straight to the final step, which holds
// until the previous response word has been taken.
module sorted_line_table_engine import slte_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_word
);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b00000001,
      ST_INS   = 8'b00000010,
      ST_CMP   = 8'b00000100,
      ST_SRCH  = 8'b00001000,
      ST_SHIFT = 8'b00010000,
      ST_BUMP  = 8'b00100000,
      ST_MAXW  = 8'b01000000,
      ST_DONE  = 8'b10000000
   } state_type;

   state_type                state_ff;
   req_type                  item_ff;
   logic [CNT_W-1:0]         total_ff;
   logic [IDX_W-1:0]         lo_ff, hi_ff, pr_ff, fl_ff, found_ff;
   logic                     phase_ff;
   logic [CNT_W-1:0]         count_ff, at_ff;
   logic [POSITION_BITS-1:0] delta_ff;
   status_type               status_ff;
   logic [WIDTH_W-1:0]       widest_ff;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_word_ff;

   cell_ctrl_type            ctrl;
   logic [TABLE_DEPTH-1:0]   ge_vec;
   logic [WIDTH_W-1:0]       max_head;

   logic [IDX_W:0]           sum;
   logic [IDX_W-1:0]         probe, probe_next, result;
   logic                     g0, g1, probing, stop;
   logic                     accept;
   logic [CNT_W-1:0]         tl_ext, fl_ext;
   status_type               chk_status;

   assign accept = req_valid && !req_stall;
   assign req_stall = state_ff != ST_IDLE;

   assign sum        = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign probe      = sum[IDX_W:1];
   assign probe_next = probe + 1'b1;
   assign g0         = ge_vec[probe];
   assign g1         = ge_vec[probe_next];
   assign probing    = lo_ff < hi_ff;
   assign stop       = !probing || (g0 && !g1);
   assign result     = probing ? probe : pr_ff;
   assign tl_ext     = {1'b0, result};
   assign fl_ext     = {1'b0, fl_ff};

   always_comb begin
      chk_status = STAT_OK;
      case (req_word.mode)
         MODE_INSERT: begin
            if (req_word.line_index > total_ff) begin
               chk_status = STAT_RANGE;
            end else if (total_ff == CNT_W'(TABLE_DEPTH)) begin
               chk_status = STAT_FULL;
            end
         end
         MODE_REMOVE_LINES: begin
            if (req_word.line_index > total_ff ||
                req_word.line_count > total_ff - req_word.line_index) begin
               chk_status = STAT_RANGE;
            end
         end
         MODE_BUMP_ORG, MODE_BUMP_OFF: begin
            if (req_word.line_index > total_ff) begin
               chk_status = STAT_RANGE;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      ctrl.op      = CELL_HOLD;
      ctrl.index   = at_ff;
      ctrl.total   = total_ff;
      ctrl.key     = pos_in(item_ff.from_offset);
      ctrl.delta   = delta_ff;
      ctrl.new_rec.offset = pos_in(item_ff.new_offset);
      ctrl.new_rec.origin = pos_in(item_ff.new_origin);
      ctrl.new_rec.width  = item_ff.new_width;
      case (state_ff)
         ST_INS:   ctrl.op = CELL_INSERT;
         ST_SHIFT: ctrl.op = CELL_SHIFT;
         ST_BUMP:  ctrl.op = (item_ff.mode == MODE_BUMP_ORG) ? CELL_BUMP_ORG : CELL_BUMP_OFF;
         ST_CMP: begin
            if (item_ff.mode == MODE_LOOKUP_PIX) begin
               ctrl.op  = CELL_CMP_ORG;
               ctrl.key = pos_in(item_ff.pixel_pos);
            end else begin
               ctrl.op  = CELL_CMP_OFF;
               ctrl.key = phase_ff ? pos_in(item_ff.to_offset) : pos_in(item_ff.from_offset);
            end
         end
         default: ;
      endcase
   end

   slte_chain u_chain (
      .clock    (clock),
      .ctrl     (ctrl),
      .ge_vec   (ge_vec),
      .max_head (max_head)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  item_ff   <= req_word;
                  at_ff     <= req_word.line_index;
                  status_ff <= chk_status;
                  found_ff  <= '0;
                  widest_ff <= '0;
                  phase_ff  <= 1'b0;
                  if (chk_status != STAT_OK) begin
                     state_ff <= ST_DONE;
                  end else begin
                     case (req_word.mode)
                        MODE_INSERT: state_ff <= ST_INS;
                        MODE_REMOVE_LINES: begin
                           if (req_word.line_count == '0) begin
                              state_ff <= ST_DONE;
                           end else begin
                              count_ff <= req_word.line_count;
                              total_ff <= total_ff - req_word.line_count;
                              state_ff <= ST_SHIFT;
                           end
                        end
                        MODE_BUMP_ORG, MODE_BUMP_OFF: begin
                           delta_ff <= pos_in(req_word.bump_delta);
                           state_ff <= ST_BUMP;
                        end
                        MODE_MAX_WIDTH: begin
                           count_ff <= '0;
                           state_ff <= ST_MAXW;
                        end
                        default: state_ff <= ST_CMP;
                     endcase
                  end
               end
            end
            ST_INS: begin
               total_ff <= total_ff + 1'b1;
               state_ff <= ST_DONE;
            end
            ST_CMP: begin
               lo_ff    <= '0;
               hi_ff    <= (total_ff == '0) ? '0 : IDX_W'(total_ff - 1'b1);
               pr_ff    <= '0;
               state_ff <= ST_SRCH;
            end
            ST_SRCH: begin
               if (probing) begin
                  pr_ff <= probe;
                  if (!stop) begin
                     if (g0) begin
                        lo_ff <= probe_next;
                     end else begin
                        hi_ff <= probe;
                     end
                  end
               end
               if (stop) begin
                  if (item_ff.mode != MODE_REMOVE_RANGE) begin
                     found_ff <= result;
                     state_ff <= ST_DONE;
                  end else if (!phase_ff) begin
                     fl_ff    <= result;
                     phase_ff <= 1'b1;
                     state_ff <= ST_CMP;
                  end else begin
                     delta_ff <= pos_in(item_ff.from_offset) - pos_in(item_ff.to_offset);
                     at_ff    <= fl_ext + 1'b1;
                     if (tl_ext > fl_ext) begin
                        count_ff <= tl_ext - fl_ext;
                        total_ff <= total_ff - (tl_ext - fl_ext);
                        state_ff <= ST_SHIFT;
                     end else begin
                        state_ff <= ST_BUMP;
                     end
                  end
               end
            end
            ST_SHIFT: begin
               count_ff <= count_ff - 1'b1;
               if (count_ff == CNT_W'(1)) begin
                  state_ff <= (item_ff.mode == MODE_REMOVE_RANGE) ? ST_BUMP : ST_DONE;
               end
            end
            ST_BUMP: state_ff <= ST_DONE;
            ST_MAXW: begin
               count_ff <= count_ff + 1'b1;
               if (count_ff == CNT_W'(TABLE_DEPTH)) begin
                  widest_ff <= max_head;
                  state_ff  <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_word_ff.found_line   <= found_ff;
                  rsp_word_ff.widest       <= widest_ff;
                  rsp_word_ff.entries_used <= total_ff;
                  rsp_word_ff.status       <= status_ff;
                  rsp_valid_ff             <= 1'b1;
                  state_ff                 <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CNT_W'(TABLE_DEPTH))
      else $error("record count above table depth");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_INS |=> total_ff == $past(total_ff) + 1'b1)
      else $error("insert did not grow the table");

   a_search_bounds: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SRCH |-> lo_ff <= hi_ff)
      else $error("search window crossed");

   a_shift_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SHIFT |-> count_ff != '0)
      else $error("shift pass with zero count");

endmodule
